// ===== rtl/version_string_parse_compare_macros.svh =====
// Assertion macros shared by the version string parser RTL.
`ifndef VERSION_STRING_PARSE_COMPARE_MACROS_SVH
`define VERSION_STRING_PARSE_COMPARE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define VSP_ASSERT_NOW(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define VSP_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/vsp_pkg.sv =====
// Shared types and constants of the version string parser.
package vsp_pkg;

   localparam int MAX_SEGMENTS = 4;
   localparam int OUT_SEGS     = 4;
   localparam int REF_SEGS     = 4;
   localparam int CMP_LEN      = (MAX_SEGMENTS > REF_SEGS) ? MAX_SEGMENTS : REF_SEGS;
   localparam int SEG_W        = 16;
   localparam int CHAR_W       = 8;
   localparam int DIGIT_W      = 4;
   localparam int PROD_W       = SEG_W + DIGIT_W;
   localparam int IDX_W        = $clog2(MAX_SEGMENTS + 1);
   localparam int TOTAL_W      = 3;
   localparam int TOTAL_MAX    = 7;
   localparam int REF_COUNT_W  = 3;
   localparam int CSR_IDX_W    = 3;
   localparam int ORDER_W      = 2;
   localparam int RSP_FIELDS_W = TOTAL_W + OUT_SEGS * SEG_W + ORDER_W;
   localparam int RSP_TDATA_W  = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W    = RSP_TDATA_W - RSP_FIELDS_W;

   localparam logic [SEG_W-1:0]  SEG_LIMIT = 16'hFFFF;
   localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;

   typedef enum logic [1:0] {
      PH_SKIP,
      PH_DIGITS,
      PH_AFTER_DOT,
      PH_DONE
   } phase_type;

   typedef enum logic [ORDER_W-1:0] {
      ORD_EQUAL = 2'd0,
      ORD_NEWER = 2'd1,
      ORD_OLDER = 2'd2
   } order_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_REF_SEG0  = 3'd0,
      CSR_REF_SEG1  = 3'd1,
      CSR_REF_SEG2  = 3'd2,
      CSR_REF_SEG3  = 3'd3,
      CSR_REF_COUNT = 3'd4
   } csr_index_type;

   typedef logic [MAX_SEGMENTS-1:0][SEG_W-1:0] seg_array_type;
   typedef logic [REF_SEGS-1:0][SEG_W-1:0]     ref_array_type;

   // Parse outcome of a string, as seen on its final character.
   typedef struct packed {
      logic [IDX_W-1:0] count;
      seg_array_type    segs;
   } parse_result_type;

endpackage

// ===== rtl/version_string_parse_compare.sv =====
// The response for a string is valid in the cycle after its last character is accepted.
// Throughput: one character per cycle while the response register is empty or being taken;
//   the parse step and compare sit between the parse state registers and that register.
// Reset: synchronous, active high; clears the parse state, the reference version
//   (all segments and count to zero) and the response valid flag.
// Top level of the dotted version string parser and comparator.
`include "version_string_parse_compare_macros.svh"

module version_string_parse_compare (
   input  logic                                clock,
   input  logic                                reset,
   // request: character stream
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [vsp_pkg::CHAR_W-1:0]          req_tdata,  // [7:0] char_in
   input  logic                                req_tlast,  // last_char
   // response: one per string
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // from bit 0 up: seg_total(3), out_seg0(16), out_seg1(16), out_seg2(16),
   // out_seg3(16), order(2), zero fill(3)
   output logic [vsp_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tuser,  // ver_valid
   // register write channel
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [vsp_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vsp_pkg::SEG_W-1:0]           csr_data
);

   logic                                  take;
   vsp_pkg::parse_result_type             parsed;
   vsp_pkg::order_type                    order;
   logic [vsp_pkg::TOTAL_W-1:0]           seg_total;
   logic [vsp_pkg::OUT_SEGS-1:0][vsp_pkg::SEG_W-1:0] out_seg;

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [vsp_pkg::RSP_TDATA_W-1:0]       rsp_data_ff, rsp_data_in;
   logic                                  rsp_user_ff, rsp_user_in;

   vsp_pkg::ref_array_type                ref_seg_ff;
   logic [vsp_pkg::REF_COUNT_W-1:0]       ref_count_ff;

   // Accept a request whenever the response register is empty or being drained.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign take       = req_tvalid && req_tready;

   vsp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .take      (take),
      .char_in   (req_tdata),
      .last_char (req_tlast),
      .result    (parsed)
   );

   vsp_compare u_compare (
      .parsed    (parsed),
      .ref_seg   (ref_seg_ff),
      .ref_count (ref_count_ff),
      .order     (order)
   );

   // Saturate the segment count to the field width; drop segments past the output list.
   always_comb begin
      seg_total = (32'(parsed.count) > vsp_pkg::TOTAL_MAX)
                ? vsp_pkg::TOTAL_W'(vsp_pkg::TOTAL_MAX) : vsp_pkg::TOTAL_W'(parsed.count);
      out_seg = '0;
      for (int i = 0; i < vsp_pkg::OUT_SEGS && i < vsp_pkg::MAX_SEGMENTS; i++) begin
         out_seg[i] = parsed.segs[i];
      end
   end

   // Load the response register on a last character, release it when taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (take && req_tlast) begin
         rsp_valid_in = 1'b1;
         rsp_user_in  = (parsed.count != '0);
         rsp_data_in  = {{vsp_pkg::RSP_PAD_W{1'b0}}, order,
                         out_seg[3], out_seg[2], out_seg[1], out_seg[0], seg_total};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Reference version registers; writes to unknown indexes are dropped.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_seg_ff   <= '0;
         ref_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (vsp_pkg::csr_index_type'(csr_index))
            vsp_pkg::CSR_REF_SEG0:  ref_seg_ff[0] <= csr_data;
            vsp_pkg::CSR_REF_SEG1:  ref_seg_ff[1] <= csr_data;
            vsp_pkg::CSR_REF_SEG2:  ref_seg_ff[2] <= csr_data;
            vsp_pkg::CSR_REF_SEG3:  ref_seg_ff[3] <= csr_data;
            vsp_pkg::CSR_REF_COUNT: ref_count_ff  <= csr_data[vsp_pkg::REF_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // An invalid version carries no segments and compares equal.
   `VSP_ASSERT_NOW(a_invalid_empty, clock, reset, rsp_tvalid && !rsp_tuser,
      rsp_tdata == '0, "invalid version response carries nonzero fields")
   // Validity and segment count agree.
   `VSP_ASSERT_NOW(a_valid_count, clock, reset, rsp_tvalid,
      rsp_tuser == (rsp_tdata[vsp_pkg::TOTAL_W-1:0] != '0), "ver_valid disagrees with seg_total")
   // A last character always produces a response next cycle.
   `VSP_ASSERT_NEXT(a_last_gives_rsp, clock, reset, take && req_tlast,
      rsp_tvalid, "last character produced no response")
   // A non-final character into an empty response slot produces nothing.
   `VSP_ASSERT_NEXT(a_mid_no_rsp, clock, reset, take && !req_tlast && !rsp_valid_ff,
      !rsp_tvalid, "response appeared without a last character")

endmodule

// ===== rtl/vsp_parser.sv =====
// Character-by-character parse state of the dotted version string.
module vsp_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic [vsp_pkg::CHAR_W-1:0]    char_in,
   input  logic                          last_char,
   output vsp_pkg::parse_result_type     result
);

   vsp_pkg::phase_type          phase_ff, phase_in;
   logic [vsp_pkg::SEG_W-1:0]   accum_ff, accum_in;
   logic [vsp_pkg::IDX_W-1:0]   idx_ff, idx_in;
   vsp_pkg::seg_array_type      store_ff, store_in;

   logic                        is_digit;
   logic [vsp_pkg::DIGIT_W-1:0] digit;
   logic [vsp_pkg::PROD_W-1:0]  prod;
   logic                        commit;
   logic                        final_commit;
   logic [vsp_pkg::SEG_W-1:0]   accum_step;
   logic [vsp_pkg::IDX_W-1:0]   idx_step;
   vsp_pkg::seg_array_type      store_step;

   assign is_digit = char_in inside {[vsp_pkg::CHAR_ZERO:vsp_pkg::CHAR_NINE]};
   assign digit    = is_digit ? vsp_pkg::DIGIT_W'(char_in - vsp_pkg::CHAR_ZERO) : '0;

   // accum * 10 + digit, wide enough to see overflow
   assign prod = ({{vsp_pkg::DIGIT_W{1'b0}}, accum_ff} << 3)
               + ({{vsp_pkg::DIGIT_W{1'b0}}, accum_ff} << 1)
               + {{vsp_pkg::SEG_W{1'b0}}, digit};

   // datapath effect of one character
   always_comb begin
      accum_step = accum_ff;
      idx_step   = idx_ff;
      store_step = store_ff;
      commit     = 1'b0;
      case (phase_ff)
         vsp_pkg::PH_SKIP, vsp_pkg::PH_AFTER_DOT: begin
            if (is_digit) accum_step = {{(vsp_pkg::SEG_W-vsp_pkg::DIGIT_W){1'b0}}, digit};
         end
         vsp_pkg::PH_DIGITS: begin
            if (is_digit) begin
               accum_step = (prod > {{vsp_pkg::DIGIT_W{1'b0}}, vsp_pkg::SEG_LIMIT})
                          ? vsp_pkg::SEG_LIMIT : prod[vsp_pkg::SEG_W-1:0];
            end else begin
               commit = 1'b1;
            end
         end
         default: ;
      endcase
      if (commit) begin
         for (int i = 0; i < vsp_pkg::MAX_SEGMENTS; i++) begin
            if (idx_ff == vsp_pkg::IDX_W'(i)) store_step[i] = accum_ff;
         end
         if (idx_ff < vsp_pkg::IDX_W'(vsp_pkg::MAX_SEGMENTS)) idx_step = idx_ff + 1'b1;
         accum_step = '0;
      end
   end

   // next phase
   always_comb begin
      phase_in = phase_ff;
      case (phase_ff)
         vsp_pkg::PH_SKIP: begin
            if (is_digit) phase_in = vsp_pkg::PH_DIGITS;
            else if (char_in == vsp_pkg::CHAR_NUL) phase_in = vsp_pkg::PH_DONE;
         end
         vsp_pkg::PH_DIGITS: begin
            if (!is_digit) begin
               if (char_in == vsp_pkg::CHAR_DOT &&
                   idx_step < vsp_pkg::IDX_W'(vsp_pkg::MAX_SEGMENTS))
                  phase_in = vsp_pkg::PH_AFTER_DOT;
               else
                  phase_in = vsp_pkg::PH_DONE;
            end
         end
         vsp_pkg::PH_AFTER_DOT: begin
            phase_in = is_digit ? vsp_pkg::PH_DIGITS : vsp_pkg::PH_DONE;
         end
         default: phase_in = vsp_pkg::PH_DONE;
      endcase
   end

   // close an open segment when the string ends inside it
   always_comb begin
      final_commit = (phase_in == vsp_pkg::PH_DIGITS);
      result.count = idx_step;
      result.segs  = store_step;
      if (final_commit) begin
         for (int i = 0; i < vsp_pkg::MAX_SEGMENTS; i++) begin
            if (idx_step == vsp_pkg::IDX_W'(i)) result.segs[i] = accum_step;
         end
         if (idx_step < vsp_pkg::IDX_W'(vsp_pkg::MAX_SEGMENTS)) result.count = idx_step + 1'b1;
      end
   end

   // a finished string leaves the state clear for the next one
   always_comb begin
      accum_in = accum_step;
      idx_in   = idx_step;
      store_in = store_step;
      if (last_char) begin
         accum_in = '0;
         idx_in   = '0;
         store_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= vsp_pkg::PH_SKIP;
         accum_ff <= '0;
         idx_ff   <= '0;
         store_ff <= '0;
      end else if (take) begin
         phase_ff <= last_char ? vsp_pkg::PH_SKIP : phase_in;
         accum_ff <= accum_in;
         idx_ff   <= idx_in;
         store_ff <= store_in;
      end
   end

endmodule

// ===== rtl/vsp_compare.sv =====
// Segment-wise ordering of a parsed version against the reference version.
module vsp_compare (
   input  vsp_pkg::parse_result_type           parsed,
   input  vsp_pkg::ref_array_type              ref_seg,
   input  logic [vsp_pkg::REF_COUNT_W-1:0]     ref_count,
   output vsp_pkg::order_type                  order
);

   logic [vsp_pkg::CMP_LEN-1:0][vsp_pkg::SEG_W-1:0] a_seg;
   logic [vsp_pkg::CMP_LEN-1:0][vsp_pkg::SEG_W-1:0] b_seg;
   logic [vsp_pkg::REF_COUNT_W-1:0]                 ref_used;

   assign ref_used = (ref_count > vsp_pkg::REF_COUNT_W'(vsp_pkg::REF_SEGS))
                   ? vsp_pkg::REF_COUNT_W'(vsp_pkg::REF_SEGS) : ref_count;

   // missing segments on either side count as zero
   always_comb begin
      a_seg = '0;
      b_seg = '0;
      for (int i = 0; i < vsp_pkg::CMP_LEN && i < vsp_pkg::MAX_SEGMENTS; i++) begin
         if (vsp_pkg::IDX_W'(i) < parsed.count) a_seg[i] = parsed.segs[i];
      end
      for (int i = 0; i < vsp_pkg::CMP_LEN && i < vsp_pkg::REF_SEGS; i++) begin
         if (vsp_pkg::REF_COUNT_W'(i) < ref_used) b_seg[i] = ref_seg[i];
      end
   end

   // the first differing segment decides; scan from the back so it wins
   always_comb begin
      order = vsp_pkg::ORD_EQUAL;
      for (int i = vsp_pkg::CMP_LEN - 1; i >= 0; i--) begin
         if (a_seg[i] > b_seg[i]) order = vsp_pkg::ORD_NEWER;
         else if (a_seg[i] < b_seg[i]) order = vsp_pkg::ORD_OLDER;
      end
      if (parsed.count == '0) order = vsp_pkg::ORD_EQUAL;
   end

endmodule
